>>> rtl/core/assert_macros.svh
// shared assertion macros, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked on every edge outside reset
`define ASSERT_CHECK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tccw: assertion failed");

// checked on edges while reset is held
`define ASSERT_IN_RESET(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) !rst_n |-> prop) \
    else $error("tccw: reset assertion failed");

`else

`define ASSERT_CHECK(name, clk, rst_n, prop)
`define ASSERT_IN_RESET(name, clk, rst_n, prop)

`endif

`endif

>>> rtl/core/tccw_pkg.sv
package tccw_pkg;

  localparam int unsigned CfgIndexWidth = 8;

  localparam logic [CfgIndexWidth-1:0] CFG_SCREEN_COLUMNS = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_SCREEN_ROWS    = 8'd1;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd25;
  localparam logic [7:0] ATTR_RESET    = 8'h07;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_MOVE     = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_LINE_END = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_CELL = 2'd0,
    KIND_FILL = 2'd1,
    KIND_ECHO = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MOD_COL,
    MOD_ROW,
    MOD_NEXT_ROW
  } mod_sel_e;

  typedef enum logic [2:0] {
    EMIT_CELL,
    EMIT_FILL,
    EMIT_ECHO_CHAR,
    EMIT_ECHO_CR,
    EMIT_ECHO_LF
  } emit_sel_e;

  typedef struct packed {
    logic      in_latch;
    logic      mod_start;
    mod_sel_e  mod_sel;
    logic      col_from_mod;
    logic      row_from_mod;
    logic      col_clear;
    logic      col_incr;
    logic      home;
    logic      emit;
    emit_sel_e emit_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic is_lf;
    logic col_nonzero;
    logic col_wrap;
    logic mod_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/core/text_console_cursor_writer.sv
// Text console cursor writer: keeps a cursor and attribute and turns each command beat
// into cell writes, a whole-screen fill request or serial echo bytes, the last beat of
// each command that emits beats marked by last_o (a move emits none). Commands are
// handled one at a time; in_ready_o is high only between commands. A newline, a line
// end with a nonzero column, a character that wraps the line and a move each reduce
// modulo the screen size, and every such reduction runs through one shared remainder
// unit at one bit per cycle. A stalled output beat holds the command until it is taken.
// Screen size is written through the cfg port (index 0 columns, 1 rows); the user must
// write it only while the block is idle, and the block itself does not enforce this.
module text_console_cursor_writer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tccw_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic [7:0]                          char_code_i,
  input  logic [7:0]                          target_column_i,
  input  logic [7:0]                          target_row_i,
  input  logic [7:0]                          new_attribute_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          kind_o,
  output logic [15:0]                         cell_index_o,
  output logic [7:0]                          glyph_o,
  output logic [7:0]                          cell_attribute_o,
  output logic [15:0]                         fill_count_o,
  output logic                                last_o
);
  import tccw_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  tccw_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .status_o         (dp_status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_in_i         (cmd_i),
    .char_code_i      (char_code_i),
    .target_column_i  (target_column_i),
    .target_row_i     (target_row_i),
    .new_attribute_i  (new_attribute_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .cell_index_o     (cell_index_o),
    .glyph_o          (glyph_o),
    .cell_attribute_o (cell_attribute_o),
    .fill_count_o     (fill_count_o),
    .last_o           (last_o)
  );

endmodule

>>> rtl/core/tccw_mod.sv
`include "assert_macros.svh"

module tccw_mod (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [7:0] divisor_i,
  output logic       done_o,
  output logic [7:0] result_o
);
  import tccw_pkg::*;

  localparam int unsigned Steps    = 8;
  localparam int unsigned CntWidth = $clog2(Steps + 1);

  logic                busy_q;
  logic [CntWidth-1:0] cnt_q;
  logic [7:0]          shift_q, shift_d;
  logic [7:0]          rem_q, rem_d;
  logic [7:0]          div_q;
  logic [8:0]          trial;
  logic [8:0]          diff;

  // restoring remainder, one dividend bit per cycle
  assign trial   = {rem_q, shift_q[7]};
  assign diff    = trial - {1'b0, div_q};
  assign rem_d   = (trial >= {1'b0, div_q}) ? diff[7:0] : trial[7:0];
  assign shift_d = {shift_q[6:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntWidth'(Steps);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntWidth'(1);
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
      div_q   <= divisor_i;
    end else if (busy_q && (cnt_q != '0)) begin
      shift_q <= shift_d;
      rem_q   <= rem_d;
    end
  end

  assign done_o   = busy_q && (cnt_q == '0);
  // a size of zero reduces every position to zero
  assign result_o = (div_q == '0) ? '0 : rem_q;

  `ASSERT_IN_RESET(a_mod_idle_in_reset, clk_i, rst_ni, !busy_q)
  `ASSERT_CHECK(a_mod_start_when_free, clk_i, rst_ni, start_i |-> (!busy_q || (cnt_q == '0)))
  `ASSERT_CHECK(a_mod_rem_below_div, clk_i, rst_ni, (done_o && (div_q != '0)) |-> (rem_q < div_q))

endmodule

>>> rtl/core/tccw_ctrl.sv
`include "assert_macros.svh"

module tccw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tccw_pkg::dp_status_t status_i,
  output tccw_pkg::ctrl_cmd_t  cmd_o
);
  import tccw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_NL_WAIT,
    S_MOVE_COL,
    S_MOVE_ROW,
    S_EMIT_CELL,
    S_EMIT_ECHO,
    S_EMIT_CR,
    S_EMIT_LF,
    S_EMIT_FILL
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mod_sel  = MOD_COL;
    cmd_o.emit_sel = EMIT_CELL;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_latch = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.cmd)
          CMD_WRITE: begin
            if (status_i.is_lf) begin
              cmd_o.mod_start = 1'b1;
              cmd_o.mod_sel   = MOD_NEXT_ROW;
              state_d = S_NL_WAIT;
            end else begin
              state_d = S_EMIT_CELL;
            end
          end
          CMD_MOVE: begin
            cmd_o.mod_start = 1'b1;
            cmd_o.mod_sel   = MOD_COL;
            state_d = S_MOVE_COL;
          end
          CMD_CLEAR: begin
            state_d = S_EMIT_FILL;
          end
          CMD_LINE_END: begin
            if (status_i.col_nonzero) begin
              cmd_o.mod_start = 1'b1;
              cmd_o.mod_sel   = MOD_NEXT_ROW;
              state_d = S_NL_WAIT;
            end else begin
              state_d = S_EMIT_CR;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_NL_WAIT: begin
        if (status_i.mod_done) begin
          cmd_o.col_clear    = 1'b1;
          cmd_o.row_from_mod = 1'b1;
          // a wrapped cell write still owes its echo
          if ((status_i.cmd == CMD_WRITE) && !status_i.is_lf) begin
            state_d = S_EMIT_ECHO;
          end else begin
            state_d = S_EMIT_CR;
          end
        end
      end
      S_MOVE_COL: begin
        if (status_i.mod_done) begin
          cmd_o.col_from_mod = 1'b1;
          cmd_o.mod_start    = 1'b1;
          cmd_o.mod_sel      = MOD_ROW;
          state_d = S_MOVE_ROW;
        end
      end
      S_MOVE_ROW: begin
        if (status_i.mod_done) begin
          cmd_o.row_from_mod = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT_CELL: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_CELL;
          if (status_i.col_wrap) begin
            cmd_o.mod_start = 1'b1;
            cmd_o.mod_sel   = MOD_NEXT_ROW;
            state_d = S_NL_WAIT;
          end else begin
            cmd_o.col_incr = 1'b1;
            state_d = S_EMIT_ECHO;
          end
        end
      end
      S_EMIT_ECHO: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_ECHO_CHAR;
          state_d = S_IDLE;
        end
      end
      S_EMIT_CR: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_ECHO_CR;
          state_d = S_EMIT_LF;
        end
      end
      S_EMIT_LF: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_ECHO_LF;
          state_d = S_IDLE;
        end
      end
      S_EMIT_FILL: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_FILL;
          cmd_o.home     = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_IN_RESET(a_ctrl_idle_in_reset, clk_i, rst_ni, state_q == S_IDLE)
  `ASSERT_CHECK(a_ctrl_emit_needs_slot, clk_i, rst_ni, cmd_o.emit |-> status_i.out_free)
  `ASSERT_CHECK(a_ctrl_done_while_waiting, clk_i, rst_ni, status_i.mod_done |-> ((state_q == S_NL_WAIT) || (state_q == S_MOVE_COL) || (state_q == S_MOVE_ROW)))

endmodule

>>> rtl/core/tccw_dpath.sv
module tccw_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tccw_pkg::ctrl_cmd_t                 cmd_i,
  output tccw_pkg::dp_status_t                status_o,
  input  logic                                cfg_valid_i,
  input  logic [tccw_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  input  logic [1:0]                          cmd_in_i,
  input  logic [7:0]                          char_code_i,
  input  logic [7:0]                          target_column_i,
  input  logic [7:0]                          target_row_i,
  input  logic [7:0]                          new_attribute_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          kind_o,
  output logic [15:0]                         cell_index_o,
  output logic [7:0]                          glyph_o,
  output logic [7:0]                          cell_attribute_o,
  output logic [15:0]                         fill_count_o,
  output logic                                last_o
);
  import tccw_pkg::*;

  logic [7:0]  cols_q, rows_q;
  logic [7:0]  col_q, row_q, attr_q;
  cmd_e        icmd_q;
  logic [7:0]  ch_q, tcol_q, trow_q, nattr_q;

  logic        mod_done;
  logic [7:0]  mod_result;
  logic [7:0]  mod_dividend, mod_divisor;

  logic [7:0]  mul_a;
  logic [15:0] product;
  logic [8:0]  col_next;

  logic        out_valid_q;
  kind_e       kind_d, kind_q;
  logic [15:0] idx_d, idx_q;
  logic [7:0]  glyph_d, glyph_q;
  logic [7:0]  attr_out_d, attr_out_q;
  logic [15:0] fill_d, fill_q;
  logic        last_d, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLUMNS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SCREEN_COLUMNS) begin
        cols_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_SCREEN_ROWS) begin
        rows_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_latch) begin
      icmd_q  <= cmd_e'(cmd_in_i);
      ch_q    <= char_code_i;
      tcol_q  <= target_column_i;
      trow_q  <= target_row_i;
      nattr_q <= new_attribute_i;
    end
  end

  always_comb begin
    unique case (cmd_i.mod_sel)
      MOD_COL: begin
        mod_dividend = tcol_q;
        mod_divisor  = cols_q;
      end
      MOD_ROW: begin
        mod_dividend = trow_q;
        mod_divisor  = rows_q;
      end
      MOD_NEXT_ROW: begin
        mod_dividend = row_q + 8'd1;
        mod_divisor  = rows_q;
      end
      default: begin
        mod_dividend = tcol_q;
        mod_divisor  = cols_q;
      end
    endcase
  end

  tccw_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (mod_divisor),
    .done_o     (mod_done),
    .result_o   (mod_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      attr_q <= ATTR_RESET;
    end else begin
      if (cmd_i.home) begin
        col_q  <= '0;
        row_q  <= '0;
        attr_q <= nattr_q;
      end
      if (cmd_i.col_clear) begin
        col_q <= '0;
      end else if (cmd_i.col_from_mod) begin
        col_q <= mod_result;
      end else if (cmd_i.col_incr) begin
        col_q <= col_next[7:0];
      end
      if (cmd_i.row_from_mod) begin
        row_q <= mod_result;
      end
    end
  end

  assign col_next = {1'b0, col_q} + 9'd1;

  // one multiplier serves both the cell offset and the fill size
  assign mul_a   = (cmd_i.emit_sel == EMIT_FILL) ? rows_q : row_q;
  assign product = {8'd0, mul_a} * {8'd0, cols_q};

  always_comb begin
    kind_d     = KIND_ECHO;
    idx_d      = '0;
    glyph_d    = ch_q;
    attr_out_d = '0;
    fill_d     = '0;
    last_d     = 1'b1;
    unique case (cmd_i.emit_sel)
      EMIT_CELL: begin
        kind_d     = KIND_CELL;
        idx_d      = product + {8'd0, col_q};
        attr_out_d = attr_q;
        last_d     = 1'b0;
      end
      EMIT_FILL: begin
        kind_d     = KIND_FILL;
        glyph_d    = CH_SPACE;
        attr_out_d = nattr_q;
        fill_d     = product;
      end
      EMIT_ECHO_CHAR: begin
        glyph_d = ch_q;
      end
      EMIT_ECHO_CR: begin
        glyph_d = CH_CR;
        last_d  = 1'b0;
      end
      EMIT_ECHO_LF: begin
        glyph_d = CH_LF;
      end
      default: begin
        glyph_d = ch_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q     <= kind_d;
      idx_q      <= idx_d;
      glyph_q    <= glyph_d;
      attr_out_q <= attr_out_d;
      fill_q     <= fill_d;
      last_q     <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign cell_index_o     = idx_q;
  assign glyph_o          = glyph_q;
  assign cell_attribute_o = attr_out_q;
  assign fill_count_o     = fill_q;
  assign last_o           = last_q;

  assign status_o.cmd         = icmd_q;
  assign status_o.is_lf       = (ch_q == CH_LF);
  assign status_o.col_nonzero = (col_q != '0);
  // past the last column, also when the cursor sits beyond a shrunken width
  assign status_o.col_wrap    = (col_next >= {1'b0, cols_q});
  assign status_o.mod_done    = mod_done;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

endmodule

>>> sim/text_console_cursor_writer_tb.sv
`timescale 1ns / 100ps

module text_console_cursor_writer_tb;
  import tccw_pkg::*;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] char_code;
    logic [7:0] target_column;
    logic [7:0] target_row;
    logic [7:0] new_attribute;
  } console_cmd_t;

  typedef struct {
    kind_e       kind;
    logic [15:0] cell_index;
    logic [7:0]  glyph;
    logic [7:0]  cell_attribute;
    logic [15:0] fill_count;
    logic        last;
  } console_beat_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [7:0]               cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               cmd_i = '0;
  logic [7:0]               char_code_i = '0;
  logic [7:0]               target_column_i = '0;
  logic [7:0]               target_row_i = '0;
  logic [7:0]               new_attribute_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [1:0]               kind_o;
  logic [15:0]              cell_index_o;
  logic [7:0]               glyph_o;
  logic [7:0]               cell_attribute_o;
  logic [15:0]              fill_count_o;
  logic                     last_o;

  console_cmd_t  pending_cmds[$];
  console_beat_t expected_beats[$];
  console_cmd_t  cmd_on_bus;
  console_beat_t next_beat;

  // shadow of the screen size and cursor state
  logic [7:0] cfg_cols = COLUMNS_RESET;
  logic [7:0] cfg_rows = ROWS_RESET;
  logic [7:0] cursor_col = 8'd0;
  logic [7:0] cursor_row = 8'd0;
  logic [7:0] cur_attr = ATTR_RESET;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic rx_hold = 1'b0;
  int   mismatches = 0;

  text_console_cursor_writer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .char_code_i      (char_code_i),
    .target_column_i  (target_column_i),
    .target_row_i     (target_row_i),
    .new_attribute_i  (new_attribute_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .cell_index_o     (cell_index_o),
    .glyph_o          (glyph_o),
    .cell_attribute_o (cell_attribute_o),
    .fill_count_o     (fill_count_o),
    .last_o           (last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] reduce_mod(input logic [7:0] v, input logic [7:0] size);
    return (size == 8'd0) ? 8'd0 : v % size;
  endfunction

  function automatic void step_to_next_line();
    cursor_col = 8'd0;
    cursor_row = reduce_mod(cursor_row + 8'd1, cfg_rows);
  endfunction

  function automatic void add_beat(input kind_e k, input logic [15:0] idx,
                                   input logic [7:0] g, input logic [7:0] a,
                                   input logic [15:0] n, input logic lst);
    console_beat_t b;
    b.kind = k;
    b.cell_index = idx;
    b.glyph = g;
    b.cell_attribute = a;
    b.fill_count = n;
    b.last = lst;
    expected_beats.push_back(b);
  endfunction

  function automatic void predict_console(input console_cmd_t c);
    int next_col;
    case (c.cmd)
      CMD_WRITE: begin
        if (c.char_code == CH_LF) begin
          step_to_next_line();
          add_beat(KIND_ECHO, 16'd0, CH_CR, 8'd0, 16'd0, 1'b0);
          add_beat(KIND_ECHO, 16'd0, CH_LF, 8'd0, 16'd0, 1'b1);
        end else begin
          // cursor may sit past a shrunken size, used as it stands
          add_beat(KIND_CELL, 16'(cursor_row) * 16'(cfg_cols) + 16'(cursor_col),
                   c.char_code, cur_attr, 16'd0, 1'b0);
          next_col = int'(cursor_col) + 1;
          if (next_col >= int'(cfg_cols)) step_to_next_line();
          else cursor_col = 8'(next_col);
          add_beat(KIND_ECHO, 16'd0, c.char_code, 8'd0, 16'd0, 1'b1);
        end
      end
      CMD_MOVE: begin
        cursor_col = reduce_mod(c.target_column, cfg_cols);
        cursor_row = reduce_mod(c.target_row, cfg_rows);
      end
      CMD_CLEAR: begin
        cur_attr = c.new_attribute;
        cursor_col = 8'd0;
        cursor_row = 8'd0;
        add_beat(KIND_FILL, 16'd0, CH_SPACE, cur_attr,
                 16'(cfg_cols) * 16'(cfg_rows), 1'b1);
      end
      default: begin
        if (cursor_col != 8'd0) step_to_next_line();
        add_beat(KIND_ECHO, 16'd0, CH_CR, 8'd0, 16'd0, 1'b0);
        add_beat(KIND_ECHO, 16'd0, CH_LF, 8'd0, 16'd0, 1'b1);
      end
    endcase
  endfunction

  function automatic console_cmd_t make_cmd(input cmd_e cmd, input logic [7:0] ch,
                                            input logic [7:0] tc, input logic [7:0] tr,
                                            input logic [7:0] na);
    console_cmd_t c;
    c.cmd = cmd;
    c.char_code = ch;
    c.target_column = tc;
    c.target_row = tr;
    c.new_attribute = na;
    return c;
  endfunction

  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int pick;
    pick = $urandom_range(99);
    c.char_code = 8'($urandom_range(255));
    c.target_column = 8'($urandom_range(255));
    c.target_row = 8'($urandom_range(255));
    c.new_attribute = 8'($urandom_range(255));
    if (pick < 55) begin
      c.cmd = CMD_WRITE;
      if ($urandom_range(9) == 0) c.char_code = CH_LF;
    end else if (pick < 72) begin
      c.cmd = CMD_MOVE;
    end else if (pick < 88) begin
      c.cmd = CMD_LINE_END;
    end else begin
      c.cmd = CMD_CLEAR;
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < 30)
      $display("%0t: %s mismatch, got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      cmd_i           <= '0;
      char_code_i     <= '0;
      target_column_i <= '0;
      target_row_i    <= '0;
      new_attribute_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) predict_console(cmd_on_bus);
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_on_bus = pending_cmds.pop_front();
          in_valid_i      <= 1'b1;
          cmd_i           <= cmd_on_bus.cmd;
          char_code_i     <= cmd_on_bus.char_code;
          target_column_i <= cmd_on_bus.target_column;
          target_row_i    <= cmd_on_bus.target_row;
          new_attribute_i <= cmd_on_bus.new_attribute;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat, kind", 16'(kind_o), 16'd0);
        end else begin
          next_beat = expected_beats.pop_front();
          if (kind_o !== next_beat.kind)
            report_mismatch("kind", 16'(kind_o), 16'(next_beat.kind));
          if (cell_index_o !== next_beat.cell_index)
            report_mismatch("cell_index", cell_index_o, next_beat.cell_index);
          if (glyph_o !== next_beat.glyph)
            report_mismatch("glyph", 16'(glyph_o), 16'(next_beat.glyph));
          if (cell_attribute_o !== next_beat.cell_attribute)
            report_mismatch("cell_attribute", 16'(cell_attribute_o),
                            16'(next_beat.cell_attribute));
          if (fill_count_o !== next_beat.fill_count)
            report_mismatch("fill_count", fill_count_o, next_beat.fill_count);
          if (last_o !== next_beat.last)
            report_mismatch("last", 16'(last_o), 16'(next_beat.last));
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_register(input logic [CfgIndexWidth-1:0] idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    if (idx == CFG_SCREEN_COLUMNS) cfg_cols = value;
    else cfg_rows = value;
  endtask

  // moves give no beat, so leave room for one to finish after the last beat
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_beats.size() != 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 48; end
      3:       begin send_idle_pct = 22; recv_stall_pct = 22; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic run_phase(input logic [7:0] cols, input logic [7:0] rows, input int n,
                           input int mode, input bit hold_off);
    write_register(CFG_SCREEN_COLUMNS, cols);
    write_register(CFG_SCREEN_ROWS, rows);
    @(negedge clk_i);
    set_idling(mode);
    // first write lands wherever the old size left the cursor
    pending_cmds.push_back(make_cmd(CMD_WRITE, 8'h78, 8'h00, 8'hFF, 8'h00));
    repeat (n) pending_cmds.push_back(random_command());
    if (hold_off) begin
      // receiver holds off long enough for the input side to back up
      rx_hold = 1'b1;
      repeat (400) @(negedge clk_i);
      rx_hold = 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset sizes, directed corner cases
    pending_cmds.push_back(make_cmd(CMD_WRITE, 8'h41, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 8'hFF, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_WRITE, CH_LF, 8'hFF, 8'hFF, 8'hFF));
    pending_cmds.push_back(make_cmd(CMD_LINE_END, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 8'h62, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_LINE_END, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pending_cmds.push_back(make_cmd(CMD_MOVE, 8'h00, 8'hFF, 8'hFF, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_MOVE, 8'hFF, 8'h00, 8'h00, 8'hFF));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'hFF));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 8'h55, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_MOVE, 8'h00, 8'd79, 8'd24, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 8'hAA, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_MOVE, 8'h00, 8'd0, 8'd24, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_WRITE, CH_LF, 8'h00, 8'h00, 8'h00));
    pending_cmds.push_back(make_cmd(CMD_MOVE, 8'h00, 8'd79, 8'd24, 8'h00));
    wait_idle();

    // cursor left at the bottom right corner before the screen shrinks
    run_phase(8'd10, 8'd4, 200, 1, 1'b1);
    run_phase(8'd255, 8'd255, 200, 2, 1'b0);
    run_phase(8'd1, 8'd1, 150, 3, 1'b0);
    run_phase(8'd0, 8'd0, 100, 0, 1'b0);
    run_phase(8'd0, 8'd9, 100, 1, 1'b0);
    run_phase(8'd6, 8'd0, 100, 2, 1'b0);
    run_phase(8'd255, 8'd1, 150, 3, 1'b0);
    run_phase(8'd1, 8'd255, 150, 0, 1'b0);
    run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 150, 1, 1'b0);
    run_phase(COLUMNS_RESET, ROWS_RESET, 100, 3, 1'b0);

    if (expected_beats.size() != 0)
      report_mismatch("beats never seen", 16'd0, 16'(expected_beats.size()));
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tccw_pkg.sv
rtl/core/tccw_mod.sv
rtl/core/tccw_ctrl.sv
rtl/core/tccw_dpath.sv
rtl/core/text_console_cursor_writer.sv
sim/text_console_cursor_writer_tb.sv
